/* hdl/tfs_pkg.sv */
// Shared types and character constants for the text format sniffer.
package tfs_pkg;

  // Format codes carried on format_code
  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_JSON    = 3'd1;
  localparam logic [2:0] FMT_XML     = 3'd2;
  localparam logic [2:0] FMT_YAML    = 3'd3;
  localparam logic [2:0] FMT_TOML    = 3'd4;
  localparam logic [2:0] FMT_CSV     = 3'd5;

  // Characters that steer the decision
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;

  // Scan phase, one-hot
  typedef enum logic [3:0] {
    PH_SKIP    = 4'b0001,
    PH_BRACKET = 4'b0010,
    PH_LINE    = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  // Per-text scan state
  typedef struct packed {
    phase_t     phase;
    logic [1:0] line_pos;
    logic       dash_ok;
    logic       name_started;
    logic       bracket_closed;
    logic       equals_seen;
    logic       equals_at_start;
    logic       colon_seen;
    logic       comma_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:           PH_SKIP,
    line_pos:        2'd0,
    dash_ok:         1'b1,
    name_started:    1'b0,
    bracket_closed:  1'b0,
    equals_seen:     1'b0,
    equals_at_start: 1'b0,
    colon_seen:      1'b0,
    comma_seen:      1'b0
  };

  // Outcome of one byte step
  typedef struct packed {
    scan_state_t st;
    logic        hit;
    logic [2:0]  code;
  } step_res_t;

endpackage

/* hdl/tfs_step.sv */
// Next-state and format decision logic for one text byte.
module tfs_step
  import tfs_pkg::*;
(
  input  scan_state_t state,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output scan_state_t state_next,
  output logic        hit,
  output logic [2:0]  code
);

  function automatic logic [2:0] line_verdict(input scan_state_t s);
    if (s.equals_seen && !s.equals_at_start) return FMT_TOML;
    if (s.colon_seen) return FMT_YAML;
    if (s.comma_seen) return FMT_CSV;
    return FMT_UNKNOWN;
  endfunction

  function automatic step_res_t line_step(input scan_state_t s, input logic [7:0] c);
    step_res_t r;
    r = '{st: s, hit: 1'b0, code: FMT_UNKNOWN};
    if (c == CH_NUL || c == CH_LF) begin
      r.hit  = 1'b1;
      r.code = line_verdict(s);
    end else begin
      if (s.line_pos != 2'd3 && c != CH_DASH) r.st.dash_ok = 1'b0;
      if (s.line_pos == 2'd2 && r.st.dash_ok) begin
        r.hit  = 1'b1;
        r.code = FMT_YAML;
      end
      if (c == CH_EQUALS && !s.equals_seen) begin
        r.st.equals_seen     = 1'b1;
        r.st.equals_at_start = (s.line_pos == 2'd0);
      end
      if (c == CH_COLON) r.st.colon_seen = 1'b1;
      if (c == CH_COMMA) r.st.comma_seen = 1'b1;
      if (s.line_pos != 2'd3) r.st.line_pos = s.line_pos + 2'd1;
    end
    return r;
  endfunction

  function automatic step_res_t bracket_step(input scan_state_t s, input logic [7:0] c);
    step_res_t r;
    r = '{st: s, hit: 1'b0, code: FMT_JSON};
    if (!s.name_started) begin
      if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER, CH_DQUOTE, CH_SQUOTE})
        r.st.name_started = 1'b1;
      else
        r.hit = 1'b1;
    end else if (!s.bracket_closed) begin
      if (c == CH_RBRACK) r.st.bracket_closed = 1'b1;
      else if (c == CH_COMMA || c == CH_LF || c == CH_NUL) r.hit = 1'b1;
    end else if (c != CH_SPACE && c != CH_TAB) begin
      r.hit = 1'b1;
      if (c == CH_NUL || c == CH_LF || c == CH_HASH) r.code = FMT_TOML;
    end
    return r;
  endfunction

  function automatic step_res_t byte_step(input scan_state_t s, input logic [7:0] c);
    step_res_t r;
    r = '{st: s, hit: 1'b0, code: FMT_UNKNOWN};
    case (s.phase)
      PH_SKIP: begin
        if (c == CH_NUL) begin
          r.hit = 1'b1;
        end else if (c <= CH_SPACE) begin
          r.hit = 1'b0;
        end else if (c == CH_LBRACK) begin
          r.st.phase = PH_BRACKET;
        end else if (c == CH_LBRACE) begin
          r.hit  = 1'b1;
          r.code = FMT_JSON;
        end else if (c == CH_LT) begin
          r.hit  = 1'b1;
          r.code = FMT_XML;
        end else begin
          r = line_step(s, c);
          r.st.phase = PH_LINE;
        end
      end
      PH_BRACKET: r = bracket_step(s, c);
      PH_LINE:    r = line_step(s, c);
      default:    r.hit = 1'b0;
    endcase
    return r;
  endfunction

  step_res_t first;
  step_res_t second;
  step_res_t final_res;

  // Run the byte, then a closing zero byte when the text ends undecided
  always_comb begin
    first     = byte_step(state, text_byte);
    second    = byte_step(first.st, CH_NUL);
    final_res = first;
    if (!first.hit && last_byte) final_res = second;
    hit  = final_res.hit && (state.phase != PH_DONE);
    code = final_res.code;
    if (last_byte) begin
      state_next = SCAN_RESET;
    end else if (final_res.hit) begin
      state_next       = final_res.st;
      state_next.phase = PH_DONE;
    end else begin
      state_next = final_res.st;
    end
  end

endmodule

/* hdl/text_format_sniffer.sv */
// Text format sniffer: guesses the format of a byte stream, one code per text.
//
// Usage: the input channel (in_valid/in_ready, text_byte, last_byte) takes one
// byte of text per beat; last_byte marks the final byte of a text. The output
// channel (out_valid/out_ready, format_code) returns exactly one format code
// per text: 0 unknown, 1 json, 2 xml, 3 yaml, 4 toml, 5 csv.
// Throughput: one byte per cycle while no decided code is held up. An accepted
// byte lands in an input register; the scan logic then updates the per-text
// state from that register, and a decided code is captured in the output
// register, so a code reaches format_code through the input and output registers.
// Bytes after the decision are consumed without producing beats.
// When the receiver stalls, the held code blocks only a byte that would make
// a new code; other bytes keep flowing until then.
// Reset (rst, synchronous) empties both registers and returns the scan state
// to skipping leading whitespace; no clearing pass is needed.
module text_format_sniffer
  import tfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] format_code
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;
  scan_state_t state;
  scan_state_t state_next;
  logic        step_hit;
  logic [2:0]  step_code;

  tfs_step u_step (
    .state      (state),
    .text_byte  (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next),
    .hit        (step_hit),
    .code       (step_code)
  );

  // Advance the held byte unless its code has nowhere to go
  assign s1_adv   = s1_valid && (!step_hit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= text_byte;
      s1_last <= last_byte;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_RESET;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && step_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && step_hit) begin
      format_code <= step_code;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && step_hit && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a decided code is blocked");

  a_last_resets_scan: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> state.phase == PH_SKIP)
    else $error("scan state not reset after final byte");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv) && $past(step_hit))
    else $error("result appeared without a decided byte");
`endif

endmodule
